// ===== hw/rtl/voice_scope_phase_tracker_unit_macros.svh =====
// Assertion macros shared by the phase tracker RTL.
`ifndef VOICE_SCOPE_PHASE_TRACKER_UNIT_MACROS_SVH
`define VOICE_SCOPE_PHASE_TRACKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define VSPT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vspt check failed");
`define VSPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vspt check failed");
`else
`define VSPT_ASSERT_SAME(lbl, ante, cons)
`define VSPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/vspt_pkg.sv =====
// Shared codes, widths and controller states of the phase tracker.
package vspt_pkg;

	localparam int FUNC_W        = 3;
	localparam int VOICE_W       = 2;
	localparam int RATE_INT_BITS = 10;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK    = 3'd0,
		FUNC_TRIGGER = 3'd1,
		FUNC_QUEUE   = 3'd2,
		FUNC_RATE    = 3'd3,
		FUNC_STOP    = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_EMIT
	} ctl_state_t;

endpackage

// ===== hw/rtl/vspt_in_if.sv =====
// Event and tick channel into the phase tracker.
interface vspt_in_if #(
	parameter int ADDRESS_BITS = 20,
	parameter int LENGTH_BITS  = 17,
	parameter int FRAC_BITS    = 16
) ();
	import vspt_pkg::*;

	logic                                valid;
	logic                                ready;
	logic [FUNC_W-1:0]                   func;
	logic [VOICE_W-1:0]                  voice;
	logic [ADDRESS_BITS-1:0]             segment_address;
	logic [LENGTH_BITS-1:0]              segment_length;
	logic                                segment_loops;
	logic [RATE_INT_BITS+FRAC_BITS-1:0]  step_rate_in;

	modport source (
		output valid, func, voice, segment_address, segment_length, segment_loops,
		       step_rate_in,
		input  ready
	);
	modport sink (
		input  valid, func, voice, segment_address, segment_length, segment_loops,
		       step_rate_in,
		output ready
	);
endinterface

// ===== hw/rtl/vspt_out_if.sv =====
// Per-voice result channel out of the phase tracker.
interface vspt_out_if #(
	parameter int ADDRESS_BITS = 20,
	parameter int LENGTH_BITS  = 17
) ();
	import vspt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [VOICE_W-1:0]      out_voice;
	logic                    voice_on;
	logic [LENGTH_BITS-1:0]  read_offset;
	logic [ADDRESS_BITS-1:0] read_address;
	logic                    loop_mode;
	logic                    last;

	modport source (
		output valid, out_voice, voice_on, read_offset, read_address, loop_mode, last,
		input  ready
	);
	modport sink (
		input  valid, out_voice, voice_on, read_offset, read_address, loop_mode, last,
		output ready
	);
endinterface

// ===== hw/rtl/vspt_rem_unit.sv =====
// Bit-serial restoring remainder of the integer phase by the segment length.
module vspt_rem_unit #(
	parameter int LENGTH_BITS = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [LENGTH_BITS:0]   dividend,
	input  logic [LENGTH_BITS-1:0] divisor,
	output logic                   done,
	output logic [LENGTH_BITS-1:0] remainder
);
	localparam int STEPS = LENGTH_BITS + 1;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [LENGTH_BITS:0]   dvd_q;
	logic [LENGTH_BITS-1:0] dsr_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [LENGTH_BITS:0]   trial;
	logic [LENGTH_BITS:0]   diff;
	logic [LENGTH_BITS-1:0] rem_nxt;

	// bring down one dividend bit; the partial remainder stays below the divisor
	always_comb begin
		trial   = {rem_q, dvd_q[LENGTH_BITS]};
		diff    = trial - {1'b0, dsr_q};
		rem_nxt = (trial >= {1'b0, dsr_q}) ? diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule

// ===== hw/rtl/voice_scope_phase_tracker_unit.sv =====
// Top level: voice state memory with read-modify-write controller.
// Events (trigger, queue, rate, stop) go through read and execute, then back to idle for the next accept.
// A tick walks the voices in order: read, update, then one result word per voice;
// a wrap that swaps in a non-empty pending segment also waits on the bit-serial
// remainder unit, and any stall on the result side holds the walk.
// Reset clears the per-voice valid bits, so every voice reads as all zero; no clear pass.
`include "voice_scope_phase_tracker_unit_macros.svh"

module voice_scope_phase_tracker_unit #(
	parameter int VOICES       = 4,
	parameter int FRAC_BITS    = 16,
	parameter int LENGTH_BITS  = 17,
	parameter int ADDRESS_BITS = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	vspt_in_if.sink   cmd,
	vspt_out_if.source res
);
	import vspt_pkg::*;

	localparam int ACC_BITS  = LENGTH_BITS + 1 + FRAC_BITS;
	localparam int RATE_BITS = RATE_INT_BITS + FRAC_BITS;
	localparam int SUMW      = (ACC_BITS > RATE_BITS) ? ACC_BITS : RATE_BITS;
	localparam int VIDX_BITS = (VOICES > 1) ? $clog2(VOICES) : 1;

	typedef struct packed {
		logic [ACC_BITS-1:0]     acc;
		logic [RATE_BITS-1:0]    rate;
		logic [LENGTH_BITS-1:0]  cur_len;
		logic [LENGTH_BITS-1:0]  nxt_len;
		logic [ADDRESS_BITS-1:0] cur_base;
		logic [ADDRESS_BITS-1:0] nxt_base;
		logic                    cur_loop;
		logic                    nxt_loop;
		logic                    active;
		logic                    retrig;
		logic [LENGTH_BITS-1:0]  int_phase;
	} voice_rec_t;

	function automatic logic [ACC_BITS-1:0] acc_add(input logic [ACC_BITS-1:0] a,
	                                                input logic [RATE_BITS-1:0] r);
		return ACC_BITS'(SUMW'(a) + SUMW'(r));
	endfunction

	// state memory and per-voice valid bits
	voice_rec_t             voice_mem_q [VOICES];
	logic [VOICES-1:0]      valid_q;
	voice_rec_t             rd_data_s1;

	ctl_state_t             state_q, state_d;
	logic [VIDX_BITS-1:0]   idx_q;

	// latched item
	logic [FUNC_W-1:0]       func_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [LENGTH_BITS-1:0]  len_q;
	logic                    loops_q;
	logic [RATE_BITS-1:0]    rate_q;

	voice_rec_t             wk_q;

	// result register
	logic                    res_valid_q;
	logic [VOICE_W-1:0]      res_voice_q;
	logic                    res_on_q;
	logic [LENGTH_BITS-1:0]  res_offset_q;
	logic [ADDRESS_BITS-1:0] res_addr_q;
	logic                    res_loop_q;
	logic                    res_last_q;

	logic                    accept;
	logic                    cmd_go;
	logic                    rd_en;
	logic                    we;
	logic                    emit;
	logic                    wk_load;
	voice_rec_t              cur;
	voice_rec_t              nx;
	logic [ACC_BITS-1:0]     span;
	logic [ACC_BITS-1:0]     wrapped;
	logic [ACC_BITS-1:0]     rem_acc;
	logic                    div_start;
	logic                    div_done;
	logic [LENGTH_BITS-1:0]  div_rem;
	logic                    idx_last;

	assign accept   = cmd.valid && cmd.ready;
	assign cur      = valid_q[idx_q] ? rd_data_s1 : '0;
	assign span     = ACC_BITS'({cur.cur_len, {FRAC_BITS{1'b0}}});
	assign wrapped  = cur.acc - span;
	assign rem_acc  = ACC_BITS'({div_rem, wk_q.acc[FRAC_BITS-1:0]});
	assign idx_last = (idx_q == VIDX_BITS'(VOICES - 1));

	// a tick always runs; an event runs only for a known code and a voice in range
	always_comb begin
		cmd_go = 1'b0;
		if (cmd.func == FUNC_TICK) begin
			cmd_go = 1'b1;
		end else if ((cmd.func == FUNC_TRIGGER || cmd.func == FUNC_QUEUE ||
		              cmd.func == FUNC_RATE || cmd.func == FUNC_STOP) &&
		             (32'(cmd.voice) < 32'(VOICES))) begin
			cmd_go = 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = (state_q == ST_IDLE);
		rd_en     = 1'b0;
		we        = 1'b0;
		emit      = 1'b0;
		wk_load   = 1'b0;
		div_start = 1'b0;
		nx        = cur;
		unique case (state_q)
			ST_IDLE: begin
				// ready is high here, so valid alone marks the accept
				if (cmd.valid && cmd_go) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (func_q)
					FUNC_TICK: begin
						priority if (cur.retrig) begin
							nx.retrig    = 1'b0;
							nx.int_phase = '0;
							nx.acc       = ACC_BITS'(cur.rate);
						end else if (!cur.active) begin
							nx = cur;
						end else if (cur.cur_len == '0) begin
							nx.active    = 1'b0;
							nx.acc       = '0;
							nx.int_phase = '0;
						end else if (cur.acc >= span) begin
							// swap in the pending segment
							nx.cur_len  = cur.nxt_len;
							nx.cur_base = cur.nxt_base;
							nx.cur_loop = cur.nxt_loop;
							if (cur.nxt_len == '0) begin
								nx.active    = 1'b0;
								nx.acc       = '0;
								nx.int_phase = '0;
							end else begin
								nx.acc = wrapped;
							end
						end else begin
							nx.int_phase = LENGTH_BITS'(cur.acc >> FRAC_BITS);
							nx.acc       = acc_add(cur.acc, cur.rate);
						end
						if (cur.active && !cur.retrig && cur.cur_len != '0 &&
						    cur.acc >= span && cur.nxt_len != '0) begin
							wk_load   = 1'b1;
							div_start = 1'b1;
							state_d   = ST_DIV;
						end else begin
							we      = 1'b1;
							emit    = 1'b1;
							state_d = ST_EMIT;
						end
					end
					FUNC_TRIGGER: begin
						nx.cur_base = addr_q;
						nx.cur_len  = len_q;
						nx.cur_loop = loops_q;
						nx.nxt_base = addr_q;
						nx.nxt_len  = len_q;
						nx.nxt_loop = loops_q;
						nx.active   = 1'b1;
						nx.retrig   = 1'b1;
						we          = 1'b1;
						state_d     = ST_IDLE;
					end
					FUNC_QUEUE: begin
						nx.nxt_base = addr_q;
						nx.nxt_len  = len_q;
						nx.nxt_loop = loops_q;
						we          = 1'b1;
						state_d     = ST_IDLE;
					end
					FUNC_RATE: begin
						nx.rate = rate_q;
						we      = 1'b1;
						state_d = ST_IDLE;
					end
					FUNC_STOP: begin
						nx.active = 1'b0;
						nx.retrig = 1'b0;
						we        = 1'b1;
						state_d   = ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DIV: begin
				nx = wk_q;
				if (div_done) begin
					nx.int_phase = div_rem;
					nx.acc       = acc_add(rem_acc, wk_q.rate);
					we           = 1'b1;
					emit         = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (res.ready) begin
					state_d = idx_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (we) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q <= (cmd.func == FUNC_TICK) ? '0 : VIDX_BITS'(cmd.voice);
			end else if (state_q == ST_EMIT && res.ready && !idx_last) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= voice_mem_q[idx_q];
		end
		if (we) begin
			voice_mem_q[idx_q] <= nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= cmd.func;
			addr_q  <= cmd.segment_address;
			len_q   <= cmd.segment_length;
			loops_q <= cmd.segment_loops;
			rate_q  <= cmd.step_rate_in;
		end
		if (wk_load) begin
			wk_q <= nx;
		end
		if (emit) begin
			res_voice_q  <= VOICE_W'(idx_q);
			res_on_q     <= nx.active;
			res_offset_q <= nx.int_phase;
			res_addr_q   <= nx.cur_base + ADDRESS_BITS'(nx.int_phase);
			res_loop_q   <= nx.cur_loop;
			res_last_q   <= idx_last;
		end
	end

	vspt_rem_unit #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wrapped[ACC_BITS-1:FRAC_BITS]),
		.divisor  (cur.nxt_len),
		.done     (div_done),
		.remainder(div_rem)
	);

	assign res.valid        = res_valid_q;
	assign res.out_voice    = res_voice_q;
	assign res.voice_on     = res_on_q;
	assign res.read_offset  = res_offset_q;
	assign res.read_address = res_addr_q;
	assign res.loop_mode    = res_loop_q;
	assign res.last         = res_last_q;

	`VSPT_ASSERT_SAME(a_no_accept_while_result, cmd.ready, !res.valid)
	`VSPT_ASSERT_SAME(a_write_needs_busy, we, state_q != ST_IDLE && state_q != ST_READ)
	`VSPT_ASSERT_NEXT(a_div_done_emits, state_q == ST_DIV && div_done,
		state_q == ST_EMIT && res.valid)
	`VSPT_ASSERT_NEXT(a_last_ends_tick, res.valid && res.ready && res.last,
		state_q == ST_IDLE && !res.valid)
endmodule

// ===== test/voice_scope_phase_tracker_unit_tb.sv =====
// Self-checking testbench for the four-voice phase tracker: directed table, random words, flow phases.
module voice_scope_phase_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vspt_pkg::*;

	localparam int VOICES       = 4;
	localparam int FRAC_BITS    = 16;
	localparam int LENGTH_BITS  = 17;
	localparam int ADDRESS_BITS = 20;
	localparam int ACC_BITS     = LENGTH_BITS + 1 + FRAC_BITS;
	localparam int RATE_BITS    = RATE_INT_BITS + FRAC_BITS;

	localparam int MAX_LEN        = 131070;
	localparam int PHASES         = 5;
	localparam int WORDS_PER_PH   = 20;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DIR_N          = 25;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [VOICE_W-1:0]      voice;
		logic [ADDRESS_BITS-1:0] addr;
		logic [LENGTH_BITS-1:0]  len;
		logic                    loops;
		logic [RATE_BITS-1:0]    rate;
	} cmd_word_t;

	typedef struct packed {
		logic [VOICE_W-1:0]      vo;
		logic                    on;
		logic [LENGTH_BITS-1:0]  off;
		logic [ADDRESS_BITS-1:0] addr;
		logic                    loopm;
		logic                    last;
	} voice_report_t;

	// one directed word; on tick rows with chk set, the report of the row's voice is typed in
	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [VOICE_W-1:0]      voice;
		logic [ADDRESS_BITS-1:0] addr;
		logic [LENGTH_BITS-1:0]  len;
		logic                    loops;
		logic [RATE_BITS-1:0]    rate;
		logic                    chk;
		logic                    exp_on;
		logic [LENGTH_BITS-1:0]  exp_off;
		logic [ADDRESS_BITS-1:0] exp_addr;
		logic                    exp_loop;
	} dir_row_t;

	dir_row_t dir_rows [DIR_N] = '{
		'{FUNC_TICK,    2'd0, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b1, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd3, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b1, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_RATE,    2'd0, 20'h00000, 17'd0,      1'b0, 26'h3FFFFFF, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TRIGGER, 2'd0, 20'hFFFFF, 17'd131070, 1'b1, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd0, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b1, 1'b1, 17'd0, 20'hFFFFF, 1'b1},
		'{FUNC_TICK,    2'd0, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd0, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_RATE,    2'd1, 20'h00000, 17'd0,      1'b0, 26'h0010000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TRIGGER, 2'd1, 20'h00000, 17'd2,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_QUEUE,   2'd1, 20'h00100, 17'd3,      1'b1, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd1, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b1, 1'b1, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd1, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd1, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_QUEUE,   2'd1, 20'h00200, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd1, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd1, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd1, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b1, 1'b0, 17'd0, 20'h00200, 1'b0},
		'{FUNC_TRIGGER, 2'd2, 20'h12345, 17'd0,      1'b1, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd2, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b1, 1'b1, 17'd0, 20'h12345, 1'b1},
		'{FUNC_TICK,    2'd2, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b1, 1'b0, 17'd0, 20'h12345, 1'b1},
		'{FUNC_STOP,    2'd0, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_UNUSED_FIRST, 2'd3, 20'hFFFFF, 17'd131070, 1'b1, 26'h3FFFFFF, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_UNUSED_LAST,  2'd3, 20'hFFFFF, 17'd131070, 1'b1, 26'h3FFFFFF, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TRIGGER, 2'd3, 20'h00000, 17'd1,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0},
		'{FUNC_TICK,    2'd0, 20'h00000, 17'd0,      1'b0, 26'h0000000, 1'b0, 1'b0, 17'd0, 20'h00000, 1'b0}
	};

	int gap_tab   [PHASES] = '{0, 73, 0, 10, 0};
	int stall_tab [PHASES] = '{0, 0, 73, 10, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vspt_in_if #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) cmd_if ();

	vspt_out_if #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) res_if ();

	voice_scope_phase_tracker_unit #(
		.VOICES      (VOICES),
		.FRAC_BITS   (FRAC_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if.sink),
		.res   (res_if.source)
	);

	always #5 clk = ~clk;

	// predicted voice state
	logic [ACC_BITS-1:0]     vs_acc      [VOICES] = '{default: '0};
	logic [RATE_BITS-1:0]    vs_rate     [VOICES] = '{default: '0};
	logic [LENGTH_BITS-1:0]  vs_cur_len  [VOICES] = '{default: '0};
	logic [LENGTH_BITS-1:0]  vs_nxt_len  [VOICES] = '{default: '0};
	logic [ADDRESS_BITS-1:0] vs_cur_base [VOICES] = '{default: '0};
	logic [ADDRESS_BITS-1:0] vs_nxt_base [VOICES] = '{default: '0};
	logic                    vs_cur_loop [VOICES] = '{default: '0};
	logic                    vs_nxt_loop [VOICES] = '{default: '0};
	logic                    vs_on       [VOICES] = '{default: '0};
	logic                    vs_retrig   [VOICES] = '{default: '0};
	logic [LENGTH_BITS-1:0]  vs_ipos     [VOICES] = '{default: '0};

	voice_report_t report_q [$];
	voice_report_t got_rep, want_rep;

	int gap_pct = 0;
	int stall_pct = 0;
	bit hold_start = 1'b0;
	bit hold_served = 1'b0;
	int errors = 0;
	int reports_checked = 0;
	int ticks_sent = 0;
	int events_sent = 0;
	int idle_cycles = 0;

	function automatic void track_word(input cmd_word_t w);
		logic [63:0] acc;
		logic [63:0] span;
		bit dead;
		voice_report_t rep;
		if (w.func == FUNC_TICK) begin
			for (int v = 0; v < VOICES; v++) begin
				acc = 64'(vs_acc[v]);
				if (vs_retrig[v]) begin
					vs_retrig[v] = 1'b0;
					vs_ipos[v] = '0;
					vs_acc[v] = ACC_BITS'(vs_rate[v]);
				end else if (vs_on[v]) begin
					span = 64'(vs_cur_len[v]) << FRAC_BITS;
					dead = (vs_cur_len[v] == '0);
					if (!dead && acc >= span) begin
						// wrap: swap in the pending segment
						acc = acc - span;
						vs_cur_len[v] = vs_nxt_len[v];
						vs_cur_base[v] = vs_nxt_base[v];
						vs_cur_loop[v] = vs_nxt_loop[v];
						span = 64'(vs_cur_len[v]) << FRAC_BITS;
						dead = (vs_cur_len[v] == '0);
						if (!dead)
							acc = acc % span;
					end
					if (dead) begin
						vs_on[v] = 1'b0;
						vs_acc[v] = '0;
						vs_ipos[v] = '0;
					end else begin
						vs_ipos[v] = acc[FRAC_BITS +: LENGTH_BITS];
						vs_acc[v] = ACC_BITS'(acc + 64'(vs_rate[v]));
					end
				end
				rep.vo = VOICE_W'(v);
				rep.on = vs_on[v];
				rep.off = vs_ipos[v];
				rep.addr = vs_cur_base[v] + ADDRESS_BITS'(vs_ipos[v]);
				rep.loopm = vs_cur_loop[v];
				rep.last = (v == VOICES - 1);
				report_q.push_back(rep);
			end
		end else begin
			case (w.func)
				FUNC_TRIGGER: begin
					vs_cur_base[w.voice] = w.addr;
					vs_cur_len[w.voice] = w.len;
					vs_cur_loop[w.voice] = w.loops;
					vs_nxt_base[w.voice] = w.addr;
					vs_nxt_len[w.voice] = w.len;
					vs_nxt_loop[w.voice] = w.loops;
					vs_on[w.voice] = 1'b1;
					vs_retrig[w.voice] = 1'b1;
				end
				FUNC_QUEUE: begin
					vs_nxt_base[w.voice] = w.addr;
					vs_nxt_len[w.voice] = w.len;
					vs_nxt_loop[w.voice] = w.loops;
				end
				FUNC_RATE: vs_rate[w.voice] = w.rate;
				FUNC_STOP: begin
					vs_on[w.voice] = 1'b0;
					vs_retrig[w.voice] = 1'b0;
				end
				default: ;
			endcase
		end
	endfunction

	// mostly short segments so wraps come often; zero lengths at the given odds out of 16
	function automatic logic [LENGTH_BITS-1:0] pick_length(input int zero_odds);
		int r;
		r = $urandom_range(15);
		if (r < zero_odds)
			return '0;
		if (r == 15)
			return LENGTH_BITS'($urandom_range(1, MAX_LEN));
		return LENGTH_BITS'($urandom_range(1, 40));
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int pick;
		int r;
		w.func = FUNC_TICK;
		w.voice = VOICE_W'($urandom);
		w.addr = ADDRESS_BITS'($urandom);
		w.len = LENGTH_BITS'($urandom_range(0, MAX_LEN));
		w.loops = 1'($urandom);
		w.rate = RATE_BITS'($urandom);
		pick = $urandom_range(99);
		if (pick < 36) begin
			w.func = FUNC_TICK;
		end else if (pick < 56) begin
			w.func = FUNC_TRIGGER;
			w.len = pick_length(1);
		end else if (pick < 70) begin
			w.func = FUNC_QUEUE;
			w.len = pick_length(3);
		end else if (pick < 84) begin
			w.func = FUNC_RATE;
			r = $urandom_range(7);
			if (r == 1)
				w.rate = '0;
			else if (r > 1)
				w.rate = RATE_BITS'($urandom_range(0, 32'h0008_0000));
		end else if (pick < 94) begin
			w.func = FUNC_STOP;
		end else begin
			w.func = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
		end
		return w;
	endfunction

	task automatic send_word(input cmd_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.func <= w.func;
		cmd_if.voice <= w.voice;
		cmd_if.segment_address <= w.addr;
		cmd_if.segment_length <= w.len;
		cmd_if.segment_loops <= w.loops;
		cmd_if.step_rate_in <= w.rate;
		do @(posedge clk); while (!cmd_if.ready);
		track_word(w);
		if (w.func == FUNC_TICK)
			ticks_sent++;
		else if (w.func <= FUNC_STOP)
			events_sent++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_start && !hold_served) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_served = 1'b1;
			end else begin
				res_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			got_rep = '{res_if.out_voice, res_if.voice_on, res_if.read_offset,
				res_if.read_address, res_if.loop_mode, res_if.last};
			if (report_q.size() == 0) begin
				$display("%t unexpected report: voice %0d on %0b offset %0d addr %h loop %0b last %0b",
					$time, got_rep.vo, got_rep.on, got_rep.off, got_rep.addr, got_rep.loopm,
					got_rep.last);
				errors++;
			end else begin
				want_rep = report_q.pop_front();
				reports_checked++;
				if (got_rep.vo !== want_rep.vo || got_rep.on !== want_rep.on ||
					got_rep.off !== want_rep.off || got_rep.addr !== want_rep.addr ||
					got_rep.loopm !== want_rep.loopm || got_rep.last !== want_rep.last) begin
					$display("%t mismatch: expected voice %0d on %0b offset %0d addr %h loop %0b last %0b",
						$time, want_rep.vo, want_rep.on, want_rep.off, want_rep.addr,
						want_rep.loopm, want_rep.last);
					$display("%t           actual voice %0d on %0b offset %0d addr %h loop %0b last %0b",
						$time, got_rep.vo, got_rep.on, got_rep.off, got_rep.addr, got_rep.loopm,
						got_rep.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%t watchdog: no progress, %0d reports outstanding", $time,
					report_q.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		cmd_word_t w;
		dir_row_t row;
		int idx;
		int sent;
		cmd_if.valid = 1'b0;
		cmd_if.func = FUNC_TICK;
		cmd_if.voice = '0;
		cmd_if.segment_address = '0;
		cmd_if.segment_length = '0;
		cmd_if.segment_loops = 1'b0;
		cmd_if.step_rate_in = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			row = dir_rows[i];
			w = '{row.func, row.voice, row.addr, row.len, row.loops, row.rate};
			send_word(w);
			if (row.chk && row.func == FUNC_TICK) begin
				idx = report_q.size() - VOICES + row.voice;
				report_q[idx].on = row.exp_on;
				report_q[idx].off = row.exp_off;
				report_q[idx].addr = row.exp_addr;
				report_q[idx].loopm = row.exp_loop;
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			gap_pct = gap_tab[ph];
			stall_pct = stall_tab[ph];
			// last phase: long result hold-off while words keep coming
			if (ph == PHASES - 1)
				hold_start = 1'b1;
			sent = 0;
			while (sent < WORDS_PER_PH) begin
				w = random_word();
				send_word(w);
				if (w.func <= FUNC_STOP)
					sent++;
			end
		end
		@(negedge clk);
		cmd_if.valid <= 1'b0;

		while (report_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (report_q.size() != 0) begin
			$display("%t %0d reports never arrived", $time, report_q.size());
			errors++;
		end

		$display("summary: %0d ticks and %0d voice events sent, %0d voice reports checked,",
			ticks_sent, events_sent, reports_checked);
		$display("summary: flow phases free, sender gaps, result stalls, mixed, long hold-off");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vspt_pkg.sv
hw/rtl/vspt_in_if.sv
hw/rtl/vspt_out_if.sv
hw/rtl/vspt_rem_unit.sv
hw/rtl/voice_scope_phase_tracker_unit.sv
test/voice_scope_phase_tracker_unit_tb.sv
